/* src/epsilon_nfa_to_nfa_converter_assert.svh */
// Assertion macros shared by the converter RTL.
`ifndef EPSILON_NFA_TO_NFA_CONVERTER_ASSERT_SVH
`define EPSILON_NFA_TO_NFA_CONVERTER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define ENFA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ENFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/enfa_pkg.sv */
// Shared types, codes and widths of the epsilon-NFA converter.
package enfa_pkg;

    localparam int CMD_W      = 2;
    localparam int STATE_W    = 4;
    localparam int SYM_W      = 3;
    localparam int SET_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int NS_W       = 5;
    localparam int NT_W       = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Highest counts the fixed field widths can address.
    localparam int STATE_LIMIT = 1 << STATE_W;
    localparam int TERM_LIMIT  = 1 << SYM_W;

    localparam int MAX_STATES_DEF    = 16;
    localparam int MAX_TERMINALS_DEF = 8;

    localparam logic [NS_W-1:0] NUM_STATES_RST    = 5'd16;
    localparam logic [NT_W-1:0] NUM_TERMINALS_RST = 4'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_SET   = 2'd0,
        CMD_LOAD_FINAL = 2'd1,
        CMD_CONVERT    = 2'd2,
        CMD_READ       = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_DONE  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_STATES    = 1'b0,
        CFG_NUM_TERMINALS = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOSE,
        S_FINAL,
        S_CONV,
        S_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               accept;
        logic               clo_step;
        logic               fin_upd;
        logic               conv_issue;
        logic               conv_last;
        logic [STATE_W-1:0] s_idx;
        logic [SYM_W-1:0]   t_idx;
        logic [STATE_W-1:0] k_idx;
    } t_dp_ctl;

endpackage

/* src/enfa_if.sv */
// Input and result channel interfaces of the converter.
interface enfa_in_if;
    import enfa_pkg::*;

    logic               valid;
    logic               ready;
    t_cmd               cmd;
    logic [STATE_W-1:0] state_index;
    logic [SYM_W-1:0]   symbol_index;
    logic               is_epsilon;
    logic [SET_W-1:0]   target_set;
    logic               final_flag;

    modport source (
        output valid, cmd, state_index, symbol_index, is_epsilon, target_set, final_flag,
        input  ready
    );
    modport sink (
        input  valid, cmd, state_index, symbol_index, is_epsilon, target_set, final_flag,
        output ready
    );
endinterface

interface enfa_out_if;
    import enfa_pkg::*;

    logic             valid;
    logic             ready;
    logic [SET_W-1:0] result_set;
    logic             result_final;
    t_status          status;

    modport source (
        output valid, result_set, result_final, status,
        input  ready
    );
    modport sink (
        input  valid, result_set, result_final, status,
        output ready
    );
endinterface

/* src/enfa_ctrl.sv */
// Controller state machine: handshakes and the closure and conversion sweeps.
module enfa_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  enfa_pkg::t_cmd           i_in_cmd,
    input  logic                     i_out_ready,
    input  logic [enfa_pkg::NS_W-1:0] i_ns,
    input  logic [enfa_pkg::NT_W-1:0] i_nt,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output enfa_pkg::t_dp_ctl        o_ctl
);
    import enfa_pkg::*;

    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [STATE_W-1:0] r_s, n_s;
    logic [STATE_W-1:0] r_k, n_k;
    logic [STATE_W-1:0] r_p, n_p;
    logic [SYM_W-1:0]   r_t, n_t;
    logic               accept;
    logic               s_last, k_last, p_last, t_last;

    assign s_last = (NS_W'(r_s) + NS_W'(1)) == i_ns;
    assign k_last = (NS_W'(r_k) + NS_W'(1)) == i_ns;
    assign p_last = (NS_W'(r_p) + NS_W'(1)) == i_ns;
    assign t_last = (NT_W'(r_t) + NT_W'(1)) == i_nt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_s         <= '0;
            r_k         <= '0;
            r_p         <= '0;
            r_t         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_s         <= n_s;
            r_k         <= n_k;
            r_p         <= n_p;
            r_t         <= n_t;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_s          = r_s;
        n_k          = r_k;
        n_p          = r_p;
        n_t          = r_t;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_in_ready   = 1'b0;
        accept       = 1'b0;
        o_ctl        = '0;
        o_ctl.s_idx  = r_s;
        o_ctl.t_idx  = r_t;
        o_ctl.k_idx  = r_k;

        case (r_state)
            S_IDLE: begin
                o_in_ready   = !r_out_valid || i_out_ready;
                accept       = o_in_ready && i_in_valid;
                o_ctl.accept = accept;
                if (accept) begin
                    if (i_in_cmd == CMD_CONVERT) begin
                        n_state = S_CLOSE;
                        n_s     = '0;
                        n_k     = '0;
                        n_p     = '0;
                        n_t     = '0;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_CLOSE: begin
                o_ctl.clo_step = 1'b1;
                if (p_last) begin
                    n_p = '0;
                    if (s_last) begin
                        n_s     = '0;
                        n_state = S_FINAL;
                    end else begin
                        n_s = r_s + STATE_W'(1);
                    end
                end else begin
                    n_p = r_p + STATE_W'(1);
                end
            end
            S_FINAL: begin
                o_ctl.fin_upd = 1'b1;
                n_state       = S_CONV;
            end
            S_CONV: begin
                o_ctl.conv_issue = 1'b1;
                o_ctl.conv_last  = k_last;
                if (k_last) begin
                    n_k = '0;
                    if (t_last) begin
                        n_t = '0;
                        if (s_last) begin
                            n_s     = '0;
                            n_state = S_DRAIN;
                        end else begin
                            n_s = r_s + STATE_W'(1);
                        end
                    end else begin
                        n_t = r_t + SYM_W'(1);
                    end
                end else begin
                    n_k = r_k + STATE_W'(1);
                end
            end
            S_DRAIN: begin
                // last converted entry is written at this edge; post the finish
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* src/enfa_datapath.sv */
// Datapath: automaton stores, closure rows, conversion accumulator and result register.
module enfa_datapath #(
    parameter int MAX_STATES    = enfa_pkg::MAX_STATES_DEF,
    parameter int MAX_TERMINALS = enfa_pkg::MAX_TERMINALS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  enfa_pkg::t_dp_ctl           i_ctl,
    input  enfa_pkg::t_cmd              i_cmd,
    input  logic [enfa_pkg::STATE_W-1:0] i_state_index,
    input  logic [enfa_pkg::SYM_W-1:0]  i_symbol_index,
    input  logic                        i_is_epsilon,
    input  logic [enfa_pkg::SET_W-1:0]  i_target_set,
    input  logic                        i_final_flag,
    input  logic [enfa_pkg::NS_W-1:0]   i_ns,
    input  logic [enfa_pkg::NT_W-1:0]   i_nt,
    output logic [enfa_pkg::SET_W-1:0]  o_result_set,
    output logic                        o_result_final,
    output enfa_pkg::t_status           o_status
);
    import enfa_pkg::*;

    localparam int ST_DEPTH   = (MAX_STATES < STATE_LIMIT) ? MAX_STATES : STATE_LIMIT;
    localparam int TERM_DEPTH = (MAX_TERMINALS < TERM_LIMIT) ? MAX_TERMINALS : TERM_LIMIT;
    localparam int ST_AW      = $clog2(ST_DEPTH);
    localparam int TAW        = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
    localparam int ENT_DEPTH  = ST_DEPTH * (1 << TAW);
    localparam int ENT_AW     = ST_AW + TAW;

    // Stores
    logic [SET_W-1:0]    mem_sym [ENT_DEPTH];
    logic [ENT_DEPTH-1:0] r_sym_vld;
    logic [ST_DEPTH-1:0] mem_cvt [ENT_DEPTH];
    logic [ENT_DEPTH-1:0] r_cvt_vld;
    logic [SET_W-1:0]    r_eps [ST_DEPTH];
    logic [ST_DEPTH-1:0] r_clo [ST_DEPTH];
    logic [ST_DEPTH-1:0] r_fin;
    logic [ST_DEPTH-1:0] r_cfin;

    // Conversion pipeline
    logic                r_cv_vld;
    logic                r_cv_last;
    logic [ST_AW-1:0]    r_cv_s;
    logic [TAW-1:0]      r_cv_t;
    logic [ST_AW-1:0]    r_cv_k;
    logic [SET_W-1:0]    r_sym_q;
    logic                r_sym_vq;
    logic [ST_DEPTH-1:0] r_acc;

    // Result register
    t_status             r_status;
    logic                r_rd_good;
    logic [ST_DEPTH-1:0] r_cvt_q;
    logic                r_cvt_vq;
    logic                r_cfin_q;

    logic                st_ok, sym_ok;
    logic [ST_AW-1:0]    st_a;
    logic [ENT_AW-1:0]   in_addr, cv_raddr;
    logic                is_convert, wr_sym, wr_eps, wr_fin, rd_cvt;
    t_status             status_in;
    logic [ST_DEPTH-1:0] act;
    logic [ST_AW-1:0]    clo_sel;
    logic [ST_DEPTH-1:0] row_sel;
    logic [ST_DEPTH-1:0] row_next;
    logic [ST_DEPTH-1:0] tg;
    logic [ST_DEPTH-1:0] contrib;
    logic [ST_DEPTH-1:0] acc_next;

    assign st_ok    = NS_W'(i_state_index) < i_ns;
    assign sym_ok   = NT_W'(i_symbol_index) < i_nt;
    assign st_a     = i_state_index[ST_AW-1:0];
    assign in_addr  = {st_a, TAW'(i_symbol_index)};
    assign cv_raddr = {i_ctl.k_idx[ST_AW-1:0], TAW'(i_ctl.t_idx)};

    assign is_convert = i_ctl.accept && (i_cmd == CMD_CONVERT);
    assign wr_sym = i_ctl.accept && (i_cmd == CMD_LOAD_SET) && st_ok && !i_is_epsilon && sym_ok;
    assign wr_eps = i_ctl.accept && (i_cmd == CMD_LOAD_SET) && st_ok && i_is_epsilon;
    assign wr_fin = i_ctl.accept && (i_cmd == CMD_LOAD_FINAL) && st_ok;
    assign rd_cvt = i_ctl.accept && (i_cmd == CMD_READ) && st_ok && sym_ok;

    always_comb begin
        case (i_cmd)
            CMD_CONVERT:    status_in = STAT_DONE;
            CMD_LOAD_SET:   status_in = (!st_ok || (!i_is_epsilon && !sym_ok)) ? STAT_RANGE
                                                                              : STAT_OK;
            CMD_LOAD_FINAL: status_in = st_ok ? STAT_OK : STAT_RANGE;
            CMD_READ:       status_in = (st_ok && sym_ok) ? STAT_OK : STAT_RANGE;
            default:        status_in = STAT_OK;
        endcase
    end

    // States in use
    always_comb begin
        for (int i = 0; i < ST_DEPTH; i++) begin
            act[i] = NS_W'(i) < i_ns;
        end
    end

    // One closure row is read at a time: the row under update, or the source row
    // of the conversion entry in flight.
    assign clo_sel = i_ctl.clo_step ? i_ctl.s_idx[ST_AW-1:0] : r_cv_s;
    assign row_sel = r_clo[clo_sel];

    // Extend the row by one epsilon step.
    always_comb begin
        row_next = row_sel;
        for (int k = 0; k < ST_DEPTH; k++) begin
            if (row_sel[k]) begin
                row_next = row_next | (r_eps[k][ST_DEPTH-1:0] & act);
            end
        end
    end

    // Closures of the targets of one closure member.
    assign tg = (r_sym_vq ? r_sym_q[ST_DEPTH-1:0] : '0) & act;

    always_comb begin
        contrib = '0;
        for (int u = 0; u < ST_DEPTH; u++) begin
            if (tg[u]) begin
                contrib = contrib | r_clo[u];
            end
        end
        if (!row_sel[r_cv_k]) begin
            contrib = '0;
        end
    end

    assign acc_next = r_acc | contrib;

    // Memories
    always_ff @(posedge i_clk) begin
        if (wr_sym) begin
            mem_sym[in_addr] <= i_target_set;
        end
        if (i_ctl.conv_issue) begin
            r_sym_q <= mem_sym[cv_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cv_vld && r_cv_last) begin
            mem_cvt[{r_cv_s, r_cv_t}] <= acc_next;
        end
        if (rd_cvt) begin
            r_cvt_q <= mem_cvt[in_addr];
        end
    end

    // Stores with a reset value, valid bits and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_vld <= '0;
            r_cvt_vld <= '0;
            r_fin     <= '0;
            r_cfin    <= '0;
            r_cv_vld  <= 1'b0;
            r_acc     <= '0;
            for (int i = 0; i < ST_DEPTH; i++) begin
                r_eps[i] <= '0;
                r_clo[i] <= '0;
            end
        end else begin
            r_cv_vld <= i_ctl.conv_issue;
            if (wr_sym) begin
                r_sym_vld[in_addr] <= 1'b1;
            end
            if (wr_eps) begin
                r_eps[st_a] <= i_target_set;
            end
            if (wr_fin) begin
                r_fin[st_a] <= i_final_flag;
            end
            if (is_convert) begin
                for (int i = 0; i < ST_DEPTH; i++) begin
                    r_clo[i] <= act[i] ? (ST_DEPTH'(1) << i) : '0;
                end
            end else if (i_ctl.clo_step) begin
                r_clo[clo_sel] <= row_next;
            end
            if (i_ctl.fin_upd) begin
                for (int i = 0; i < ST_DEPTH; i++) begin
                    r_cfin[i] <= act[i] && |(r_clo[i] & r_fin & act);
                end
            end
            if (is_convert) begin
                // entries the sweep does not reach read as empty afterwards
                r_cvt_vld <= '0;
            end else if (r_cv_vld && r_cv_last) begin
                r_cvt_vld[{r_cv_s, r_cv_t}] <= 1'b1;
            end
            if (r_cv_vld) begin
                if (r_cv_last) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= acc_next;
                end
            end
        end
    end

    // Pipeline and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.conv_issue) begin
            r_cv_last <= i_ctl.conv_last;
            r_cv_s    <= i_ctl.s_idx[ST_AW-1:0];
            r_cv_t    <= TAW'(i_ctl.t_idx);
            r_cv_k    <= i_ctl.k_idx[ST_AW-1:0];
            r_sym_vq  <= r_sym_vld[cv_raddr];
        end
        if (i_ctl.accept) begin
            r_status  <= status_in;
            r_rd_good <= rd_cvt;
        end
        if (rd_cvt) begin
            r_cvt_vq <= r_cvt_vld[in_addr];
            r_cfin_q <= r_cfin[st_a];
        end
    end

    assign o_result_set   = (r_rd_good && r_cvt_vq) ? SET_W'(r_cvt_q) : '0;
    assign o_result_final = r_rd_good && r_cfin_q;
    assign o_status       = r_status;

endmodule

/* src/epsilon_nfa_to_nfa_converter.sv */
// Top level of the epsilon-NFA to NFA converter.
//
// Input channel i_in carries one command per transaction: load a terminal or
// epsilon target set, load a final mark, convert, or read a converted entry.
// Result channel o_out returns exactly one transaction for each command:
// the converted set and final mark on a good read, zeros otherwise, and a
// status (accepted, conversion finished, index out of range).
// For loads and reads, the result is valid in the cycle after
// the input transaction, and the next command is taken at once while the
// result register is empty or being drained, so one command per cycle.
// A convert runs the closure sweep (one row update per cycle, set by the shared
// epsilon-step unit), a final-mark update, then the conversion sweep (one
// symbol-store read per cycle, set by that store's single read port) and a
// drain state, then posts its result. No command is taken meanwhile.
// ns and nt are the configured counts held within 1..16 and 1..8. Reset clears
// the valid bits, the epsilon, closure and final stores and the result valid
// flag; the block is ready the cycle after reset. When the receiver stalls, hold
// the result and take no new command. Configuration writes go through i_cfg_*;
// the user must make them only when idle, as the block does not enforce it.
`include "epsilon_nfa_to_nfa_converter_assert.svh"

module epsilon_nfa_to_nfa_converter #(
    parameter int MAX_STATES    = enfa_pkg::MAX_STATES_DEF,
    parameter int MAX_TERMINALS = enfa_pkg::MAX_TERMINALS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [enfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [enfa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    enfa_in_if.sink                        i_in,
    enfa_out_if.source                     o_out
);
    import enfa_pkg::*;

    // Counts beyond what the index fields can address change no visible result.
    localparam int ST_DEPTH   = (MAX_STATES < STATE_LIMIT) ? MAX_STATES : STATE_LIMIT;
    localparam int TERM_DEPTH = (MAX_TERMINALS < TERM_LIMIT) ? MAX_TERMINALS : TERM_LIMIT;

    logic [NS_W-1:0] r_num_states;
    logic [NT_W-1:0] r_num_terminals;
    logic [NS_W-1:0] ns_eff;
    logic [NT_W-1:0] nt_eff;
    t_dp_ctl         dp_ctl;
    logic            in_ready;
    logic            out_valid;
    logic            in_acc;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states    <= NUM_STATES_RST;
            r_num_terminals <= NUM_TERMINALS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NUM_STATES:    r_num_states    <= i_cfg_data[NS_W-1:0];
                CFG_NUM_TERMINALS: r_num_terminals <= i_cfg_data[NT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the counts: zero acts as one, large values as the store depth.
    always_comb begin
        if (r_num_states == '0) begin
            ns_eff = NS_W'(1);
        end else if (r_num_states > NS_W'(ST_DEPTH)) begin
            ns_eff = NS_W'(ST_DEPTH);
        end else begin
            ns_eff = r_num_states;
        end
        if (r_num_terminals == '0) begin
            nt_eff = NT_W'(1);
        end else if (r_num_terminals > NT_W'(TERM_DEPTH)) begin
            nt_eff = NT_W'(TERM_DEPTH);
        end else begin
            nt_eff = r_num_terminals;
        end
    end

    enfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .i_out_ready (o_out.ready),
        .i_ns        (ns_eff),
        .i_nt        (nt_eff),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_ctl       (dp_ctl)
    );

    enfa_datapath #(
        .MAX_STATES    (MAX_STATES),
        .MAX_TERMINALS (MAX_TERMINALS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (dp_ctl),
        .i_cmd          (i_in.cmd),
        .i_state_index  (i_in.state_index),
        .i_symbol_index (i_in.symbol_index),
        .i_is_epsilon   (i_in.is_epsilon),
        .i_target_set   (i_in.target_set),
        .i_final_flag   (i_in.final_flag),
        .i_ns           (ns_eff),
        .i_nt           (nt_eff),
        .o_result_set   (o_out.result_set),
        .o_result_final (o_out.result_final),
        .o_status       (o_out.status)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign in_acc      = i_in.valid && i_in.ready;

    // A stalled result must never be overwritten by a new command.
    `ENFA_ASSERT_IMPL(a_hold_on_stall, i_clk, i_rst_n, o_out.valid && !o_out.ready, !i_in.ready, "command taken while a result is stalled")
    // Loads and reads answer in the next cycle.
    `ENFA_ASSERT_NEXT(a_item_result, i_clk, i_rst_n, in_acc && (i_in.cmd != CMD_CONVERT), o_out.valid, "load or read result missing")
    // A convert goes busy: no result and no new command in the next cycle.
    `ENFA_ASSERT_NEXT(a_convert_busy, i_clk, i_rst_n, in_acc && (i_in.cmd == CMD_CONVERT), !o_out.valid && !i_in.ready, "convert did not enter its sweep")
    // Anything but a good read carries an empty payload.
    `ENFA_ASSERT_IMPL(a_zero_payload, i_clk, i_rst_n, o_out.valid && (o_out.status != STAT_OK), (o_out.result_set == '0) && !o_out.result_final, "payload set on a non-read result")

endmodule
